### hw/rtl/header_length_deframer_assert.svh
// Assertion macros for the header length deframer checker.
// No dependencies; included by the checker file.
`ifndef HEADER_LENGTH_DEFRAMER_ASSERT_SVH
`define HEADER_LENGTH_DEFRAMER_ASSERT_SVH

// Checked property, skipped while reset is asserted
`define HLD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must hold at edges where reset is asserted
`define HLD_ASSERT_IN_RESET(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) !rst_n |-> prop) else $error(msg);

`endif

### hw/rtl/hld_pkg.sv
// Shared types and constants for the header length deframer.
// No dependencies; used by every RTL file of the block.
package hld_pkg;

    localparam int BYTE_W       = 8;
    localparam int HDR_W        = 64;
    localparam int HDR_LEN_W    = 4;
    localparam int LEN_W        = 32;
    localparam int CFG_INDEX_W  = 1;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [HDR_LEN_W-1:0] HDR_LEN_RESET = 4'd4;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HEADER_BYTES  = 1'b0,
        REG_HEADER_LENGTH = 1'b1
    } hld_reg_t;

    // Configuration as seen by the parser
    typedef struct packed {
        logic [HDR_W-1:0]     header_bytes;
        logic [HDR_LEN_W-1:0] header_length;
    } hld_cfg_t;

    // One body byte on its way to the output
    typedef struct packed {
        logic [BYTE_W-1:0] body_byte;
        logic              body_last;
    } hld_entry_t;

endpackage

### hw/rtl/hld_intf.sv
// Channel interfaces: received bytes in, body bytes out.
// Depends on hld_pkg.
interface hld_rx_if;
    logic                      valid;
    logic                      ready;
    logic [hld_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hld_body_if;
    logic                      valid;
    logic                      ready;
    logic [hld_pkg::BYTE_W-1:0] body_byte;
    logic                      body_last;

    modport source (output valid, output body_byte, output body_last, input ready);
    modport sink   (input valid, input body_byte, input body_last, output ready);
endinterface

### hw/rtl/header_length_deframer.sv
// Header length deframer, top level: configuration registers, parser front end,
// body queue and output stage. Depends on hld_pkg, hld_intf, hld_front, hld_queue, hld_back.
// Throughput: one byte per cycle; rx.ready drops only when the two-entry queue is full.
// Path: a body byte accepted on rx is pushed into the queue, then registered in the output reg and shown on body.
// An output stall can hold it in the queue. Header, flag and length bytes give no body output.
// Reset: asynchronous active low; parser hunts header, queue and output empty, header_length 4.
module header_length_deframer #(
    parameter int MAX_HEADER_BYTES = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    hld_rx_if.sink                          rx,
    hld_body_if.source                      body,
    input  logic                            cfg_we,
    input  logic [hld_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hld_pkg::HDR_W-1:0]       cfg_data
);
    import hld_pkg::*;

    hld_cfg_t   cfg_reg;
    logic       queue_full;
    logic       push;
    hld_entry_t push_entry;
    logic       pop;
    logic       queue_not_empty;
    hld_entry_t queue_head;
    hld_entry_t out_entry;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_bytes  <= '0;
            cfg_reg.header_length <= HDR_LEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (hld_reg_t'(cfg_index))
                REG_HEADER_BYTES:  cfg_reg.header_bytes  <= cfg_data;
                REG_HEADER_LENGTH: cfg_reg.header_length <= cfg_data[HDR_LEN_W-1:0];
            endcase
        end
    end

    hld_front #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (rx.valid),
        .in_byte    (rx.rx_byte),
        .in_ready   (rx.ready),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    hld_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (queue_not_empty),
        .head       (queue_head)
    );

    hld_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (queue_not_empty),
        .head      (queue_head),
        .pop       (pop),
        .out_valid (body.valid),
        .out_entry (out_entry),
        .out_ready (body.ready)
    );

    assign body.body_byte = out_entry.body_byte;
    assign body.body_last = out_entry.body_last;

endmodule

### hw/rtl/hld_front.sv
// Front end: accepts stream bytes, hunts the header, parses flag and length,
// and pushes body bytes into the queue. Depends on hld_pkg.
module hld_front #(
    parameter int MAX_HEADER_BYTES = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  hld_pkg::hld_cfg_t          cfg,
    input  logic                       in_valid,
    input  logic [hld_pkg::BYTE_W-1:0] in_byte,
    output logic                       in_ready,
    input  logic                       queue_full,
    output logic                       push,
    output hld_pkg::hld_entry_t        push_entry
);
    import hld_pkg::*;

    localparam int MATCH_W = $clog2(MAX_HEADER_BYTES + 1);
    localparam logic [HDR_LEN_W-1:0] MAX_LEN = HDR_LEN_W'(MAX_HEADER_BYTES);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_FLAG,
        PH_LEN,
        PH_BODY
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [MATCH_W-1:0] header_matched_reg, header_matched_next;
    logic [LEN_W-1:0]   length_shift_reg, length_shift_next;
    logic [1:0]         length_seen_reg, length_seen_next;
    logic [LEN_W-1:0]   body_remaining_reg, body_remaining_next;

    logic               accept;
    logic [HDR_LEN_W-1:0] eff_len;
    logic [MATCH_W-1:0] match_start;
    logic [MATCH_W-1:0] match_step;
    logic [2:0]         pos_cur, pos_first;
    logic [BYTE_W-1:0]  exp_cur, exp_first;
    logic [LEN_W-1:0]   length_full;
    logic [LEN_W-1:0]   remaining_dec;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // Effective header length, clamped to 1..MAX_HEADER_BYTES
    always_comb
    begin
        if (cfg.header_length == '0)
            eff_len = HDR_LEN_W'(1);
        else if (cfg.header_length > MAX_LEN)
            eff_len = MAX_LEN;
        else
            eff_len = cfg.header_length;
    end

    // Expected header bytes: current match position and the first byte
    assign match_start = (HDR_LEN_W'(header_matched_reg) >= eff_len) ? '0 : header_matched_reg;
    assign pos_cur     = 3'(eff_len - HDR_LEN_W'(1) - HDR_LEN_W'(match_start));
    assign pos_first   = 3'(eff_len - HDR_LEN_W'(1));
    assign exp_cur     = cfg.header_bytes[{pos_cur, 3'b000} +: BYTE_W];
    assign exp_first   = cfg.header_bytes[{pos_first, 3'b000} +: BYTE_W];

    // Mismatch retests the current byte as the first header byte
    always_comb
    begin
        if (in_byte == exp_cur)
            match_step = match_start + MATCH_W'(1);
        else if (in_byte == exp_first)
            match_step = MATCH_W'(1);
        else
            match_step = '0;
    end

    assign length_full   = {length_shift_reg[LEN_W-BYTE_W-1:0], in_byte};
    assign remaining_dec = body_remaining_reg - LEN_W'(1);

    // Parser next state
    always_comb
    begin
        phase_next          = phase_reg;
        header_matched_next = header_matched_reg;
        length_shift_next   = length_shift_reg;
        length_seen_next    = length_seen_reg;
        body_remaining_next = body_remaining_reg;
        push                = 1'b0;
        push_entry.body_byte = in_byte;
        push_entry.body_last = (remaining_dec == '0);

        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (HDR_LEN_W'(match_step) >= eff_len)
                    begin
                        header_matched_next = '0;
                        phase_next          = PH_FLAG;
                    end
                    else
                    begin
                        header_matched_next = match_step;
                    end
                end
                PH_FLAG:
                begin
                    length_shift_next = '0;
                    length_seen_next  = '0;
                    phase_next        = PH_LEN;
                end
                PH_LEN:
                begin
                    length_shift_next = length_full;
                    if (length_seen_reg == 2'd3)
                    begin
                        length_seen_next    = '0;
                        body_remaining_next = length_full;
                        phase_next          = (length_full == '0) ? PH_HUNT : PH_BODY;
                    end
                    else
                    begin
                        length_seen_next = length_seen_reg + 2'd1;
                    end
                end
                PH_BODY:
                begin
                    if (body_remaining_reg == '0)
                    begin
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        push                = 1'b1;
                        body_remaining_next = remaining_dec;
                        if (remaining_dec == '0)
                            phase_next = PH_HUNT;
                    end
                end
            endcase
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HUNT;
            header_matched_reg <= '0;
            length_shift_reg   <= '0;
            length_seen_reg    <= '0;
            body_remaining_reg <= '0;
        end
        else
        begin
            phase_reg          <= phase_next;
            header_matched_reg <= header_matched_next;
            length_shift_reg   <= length_shift_next;
            length_seen_reg    <= length_seen_next;
            body_remaining_reg <= body_remaining_next;
        end
    end

endmodule

### hw/rtl/hld_queue.sv
// Short FIFO of body bytes between the parser and the output stage.
// Depends on hld_pkg.
module hld_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  hld_pkg::hld_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output hld_pkg::hld_entry_t head
);
    import hld_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    hld_entry_t         entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

### hw/rtl/hld_back.sv
// Back end: output register that drains the queue toward the body channel.
// Depends on hld_pkg.
module hld_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                not_empty,
    input  hld_pkg::hld_entry_t head,
    output logic                pop,
    output logic                out_valid,
    output hld_pkg::hld_entry_t out_entry,
    input  logic                out_ready
);
    import hld_pkg::*;

    logic       valid_reg, valid_next;
    hld_entry_t data_reg;

    // Load when the register is empty or being drained this cycle
    assign pop        = not_empty && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_entry  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= head;
    end

endmodule

### hw/rtl/header_length_deframer_checker.sv
// Port-level assertions for the header length deframer, with bind to the top.
// Depends on hld_pkg and header_length_deframer_assert.svh.
`include "header_length_deframer_assert.svh"

module header_length_deframer_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       rx_ready,
    input logic                       body_valid,
    input logic                       body_ready,
    input logic [hld_pkg::BYTE_W-1:0] body_byte,
    input logic                       body_last
);
    import hld_pkg::*;

    logic              out_stall;
    logic [BYTE_W+1:0] out_word;

    assign out_stall = body_valid && !body_ready;
    assign out_word  = {body_valid, body_byte, body_last};

    // Output register is empty while in reset
    `HLD_ASSERT_IN_RESET(a_no_out_in_reset, clk, rst_n, !body_valid, "body valid during reset")

    // A stalled transaction keeps its payload
    `HLD_ASSERT(a_out_hold, clk, rst_n, out_stall |=> $stable(out_word), "stalled body changed")

    // Sink readiness drains the queue below full, so rx is ready in the next cycle
    `HLD_ASSERT(a_rx_flows, clk, rst_n, $past(body_ready) |-> rx_ready, "rx stalled after sink ready")

    // Input backpressure only comes from a blocked output
    `HLD_ASSERT(a_stall_cause, clk, rst_n, !rx_ready |-> body_valid, "rx stalled with output empty")

endmodule

bind header_length_deframer header_length_deframer_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rx_ready   (rx.ready),
    .body_valid (body.valid),
    .body_ready (body.ready),
    .body_byte  (body.body_byte),
    .body_last  (body.body_last)
);
